[src/mhd_pkg.sv]
// shared constants and command/status types for the merging max-heap
package mhd_pkg;

	localparam int HEAP_CAPACITY_DEF = 1024;
	localparam int DEGREE_COUNT_DEF  = 1024;
	localparam int COEF_BITS_DEF     = 32;
	localparam int ID_BITS_DEF       = 16;

	localparam int FUNC_W   = 2;
	localparam int DEG_W    = 10;
	localparam int COEF_W   = 32;
	localparam int SRC_W    = 16;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 11;

	localparam logic [FUNC_W-1:0] FN_INSERT  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_EXTRACT = 2'd1;
	localparam logic [FUNC_W-1:0] FN_PEEK    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic clr;
		logic load;
		logic deg_rd;
		logic merge_wr;
		logic set_full;
		logic set_empty;
		logic mark_wr;
		logic place;
		logic up_rd;
		logic up_move;
		logic top_rd;
		logic top_cap;
		logic last_rd;
		logic last_cap;
		logic sum_cap;
		logic rd_l;
		logic cap_l;
		logic rd_r;
		logic cap_r;
		logic dn_move;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic in_range;
		logic present;
		logic full;
		logic empty;
		logic at_root;
		logic up_stop;
		logic has_l;
		logic has_r;
		logic pick_none;
		logic out_free;
		logic clr_last;
	} sts_t;

endpackage

[src/mhd_dpath.sv]
// datapath: heap memory, degree accumulator memory, work and output registers
module mhd_dpath #(
	parameter int HEAP_CAPACITY = 1024,
	parameter int DEGREE_COUNT  = 1024,
	parameter int COEF_BITS     = 32,
	parameter int ID_BITS       = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mhd_pkg::cmd_t                 cmd,
	output mhd_pkg::sts_t                 sts,
	input  logic [mhd_pkg::FUNC_W-1:0]    func,
	input  logic [mhd_pkg::DEG_W-1:0]     degree,
	input  logic signed [mhd_pkg::COEF_W-1:0] coef,
	input  logic [mhd_pkg::SRC_W-1:0]     source_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mhd_pkg::STATUS_W-1:0]  status,
	output logic [mhd_pkg::DEG_W-1:0]     out_degree,
	output logic signed [mhd_pkg::COEF_W-1:0] out_coef,
	output logic [mhd_pkg::SRC_W-1:0]     out_source_id,
	output logic                          merged,
	output logic [mhd_pkg::TOTAL_W-1:0]   entry_total
);
	import mhd_pkg::*;

	localparam int HIDX_W = $clog2(HEAP_CAPACITY);
	localparam int CNT_W  = $clog2(HEAP_CAPACITY + 1);
	localparam int DIDX_W = $clog2(DEGREE_COUNT);

	typedef struct packed {
		logic [DEG_W-1:0]     deg;
		logic [COEF_BITS-1:0] coef;
		logic [ID_BITS-1:0]   id;
	} term_t;

	term_t                heap_mem [HEAP_CAPACITY];
	logic [COEF_BITS:0]   dm_mem [DEGREE_COUNT];

	term_t                hp_rd_q;
	logic [COEF_BITS:0]   dm_rd_q;
	logic [FUNC_W-1:0]    func_q;
	term_t                term_q;
	term_t                elem_q;
	term_t                top_q;
	term_t                left_q;
	term_t                right_q;
	logic [HIDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [COEF_BITS-1:0] acc_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic                 res_merged_q;
	logic                 show_q;
	logic [DIDX_W-1:0]    clr_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [DEG_W-1:0]     out_deg_q;
	logic [COEF_W-1:0]    out_coef_q;
	logic [SRC_W-1:0]     out_id_q;
	logic                 out_merged_q;
	logic [TOTAL_W-1:0]   out_total_q;

	logic [HIDX_W-1:0]    pidx;
	logic [HIDX_W-1:0]    last_idx;
	logic [CNT_W:0]       l_w;
	logic [CNT_W:0]       r_w;
	logic                 l_big;
	logic                 r_big;
	term_t                child;
	logic [HIDX_W-1:0]    child_idx;
	logic                 hp_re;
	logic [HIDX_W-1:0]    hp_ra;
	logic                 hp_we;
	term_t                hp_wd;
	logic                 dm_re;
	logic [DIDX_W-1:0]    dm_ra;
	logic                 dm_we;
	logic [DIDX_W-1:0]    dm_wa;
	logic [COEF_BITS:0]   dm_wd;

	assign pidx      = (idx_q - HIDX_W'(1)) >> 1;
	assign last_idx  = HIDX_W'(cnt_q - CNT_W'(1));
	assign l_w       = (CNT_W + 1)'({idx_q, 1'b1});
	assign r_w       = l_w + (CNT_W + 1)'(1);
	assign l_big     = left_q.deg > elem_q.deg;
	assign r_big     = (r_w < {1'b0, cnt_q}) &&
		(right_q.deg > (l_big ? left_q.deg : elem_q.deg));
	assign child     = r_big ? right_q : left_q;
	assign child_idx = r_big ? r_w[HIDX_W-1:0] : l_w[HIDX_W-1:0];

	always_comb begin
		sts.func      = func_q;
		sts.in_range  = 32'(term_q.deg) < DEGREE_COUNT;
		sts.present   = dm_rd_q[COEF_BITS];
		sts.full      = cnt_q == CNT_W'(HEAP_CAPACITY);
		sts.empty     = cnt_q == '0;
		sts.at_root   = idx_q == '0;
		sts.up_stop   = hp_rd_q.deg >= elem_q.deg;
		sts.has_l     = l_w < {1'b0, cnt_q};
		sts.has_r     = r_w < {1'b0, cnt_q};
		sts.pick_none = !l_big && !r_big;
		sts.out_free  = !out_valid_q || out_ready;
		sts.clr_last  = clr_q == DIDX_W'(DEGREE_COUNT - 1);
	end

	// heap port selection
	always_comb begin
		hp_re = cmd.up_rd || cmd.top_rd || cmd.last_rd || cmd.rd_l || cmd.rd_r;
		hp_ra = '0;
		if (cmd.up_rd) begin
			hp_ra = pidx;
		end else if (cmd.last_rd) begin
			hp_ra = last_idx;
		end else if (cmd.rd_l) begin
			hp_ra = l_w[HIDX_W-1:0];
		end else if (cmd.rd_r) begin
			hp_ra = r_w[HIDX_W-1:0];
		end
		hp_we = cmd.place || cmd.up_move || cmd.dn_move;
		if (cmd.place) begin
			hp_wd = elem_q;
		end else if (cmd.up_move) begin
			hp_wd = hp_rd_q;
		end else begin
			hp_wd = child;
		end
	end

	// accumulator port selection
	always_comb begin
		dm_re = cmd.deg_rd || cmd.last_cap;
		dm_ra = cmd.deg_rd ? DIDX_W'(term_q.deg) : DIDX_W'(top_q.deg);
		dm_we = cmd.clr || cmd.merge_wr || cmd.mark_wr || cmd.sum_cap;
		dm_wa = DIDX_W'(term_q.deg);
		dm_wd = '0;
		if (cmd.clr) begin
			dm_wa = clr_q;
		end else if (cmd.sum_cap) begin
			dm_wa = DIDX_W'(top_q.deg);
		end else if (cmd.merge_wr) begin
			dm_wd = {1'b1, dm_rd_q[COEF_BITS-1:0] + term_q.coef};
		end else if (cmd.mark_wr) begin
			dm_wd = {1'b1, {COEF_BITS{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		if (hp_we) begin
			heap_mem[idx_q] <= hp_wd;
		end
		if (hp_re) begin
			hp_rd_q <= heap_mem[hp_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (dm_we) begin
			dm_mem[dm_wa] <= dm_wd;
		end
		if (dm_re) begin
			dm_rd_q <= dm_mem[dm_ra];
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q       <= func;
			term_q.deg   <= degree;
			term_q.coef  <= COEF_BITS'(coef);
			term_q.id    <= ID_BITS'(source_id);
			res_status_q <= ST_OK;
			res_merged_q <= 1'b0;
			show_q       <= 1'b0;
		end
		if (cmd.merge_wr) begin
			res_merged_q <= 1'b1;
		end
		if (cmd.set_full) begin
			res_status_q <= ST_FULL;
		end
		if (cmd.set_empty) begin
			res_status_q <= ST_EMPTY;
		end
		if (cmd.mark_wr) begin
			elem_q <= term_q;
		end
		if (cmd.top_cap) begin
			top_q  <= hp_rd_q;
			acc_q  <= hp_rd_q.coef;
			show_q <= 1'b1;
		end
		if (cmd.last_cap) begin
			elem_q <= hp_rd_q;
		end
		if (cmd.sum_cap) begin
			acc_q <= top_q.coef + dm_rd_q[COEF_BITS-1:0];
		end
		if (cmd.cap_l) begin
			left_q <= hp_rd_q;
		end
		if (cmd.cap_r) begin
			right_q <= hp_rd_q;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_deg_q    <= show_q ? top_q.deg : '0;
			out_coef_q   <= show_q ? COEF_W'($signed(acc_q)) : '0;
			out_id_q     <= show_q ? SRC_W'(top_q.id) : '0;
			out_merged_q <= res_merged_q;
			out_total_q  <= TOTAL_W'(cnt_q);
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + DIDX_W'(1);
			end
			if (cmd.mark_wr) begin
				idx_q <= HIDX_W'(cnt_q);
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.up_move) begin
				idx_q <= pidx;
			end
			if (cmd.last_rd) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (cmd.sum_cap) begin
				idx_q <= '0;
			end
			if (cmd.dn_move) begin
				idx_q <= child_idx;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign out_degree    = out_deg_q;
	assign out_coef      = out_coef_q;
	assign out_source_id = out_id_q;
	assign merged        = out_merged_q;
	assign entry_total   = out_total_q;

endmodule

[src/mhd_ctrl.sv]
// controller state machine sequencing insert, sift-up, extract and sift-down
module mhd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mhd_pkg::sts_t sts,
	output mhd_pkg::cmd_t cmd
);
	import mhd_pkg::*;

	typedef enum logic [13:0] {
		S_CLEAR = 14'b00000000000001,
		S_IDLE  = 14'b00000000000010,
		S_DISP  = 14'b00000000000100,
		S_DCHK  = 14'b00000000001000,
		S_UP    = 14'b00000000010000,
		S_UPCMP = 14'b00000000100000,
		S_TOPD  = 14'b00000001000000,
		S_LAST  = 14'b00000010000000,
		S_SUM   = 14'b00000100000000,
		S_DN    = 14'b00001000000000,
		S_DNL   = 14'b00010000000000,
		S_DNR   = 14'b00100000000000,
		S_DNC   = 14'b01000000000000,
		S_FIN   = 14'b10000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_FIN;
				if (sts.func == FN_INSERT) begin
					if (sts.in_range) begin
						cmd.deg_rd = 1'b1;
						state_d    = S_DCHK;
					end
				end else if (sts.func == FN_EXTRACT || sts.func == FN_PEEK) begin
					if (sts.empty) begin
						cmd.set_empty = 1'b1;
					end else begin
						cmd.top_rd = 1'b1;
						state_d    = S_TOPD;
					end
				end
			end
			S_DCHK: begin
				state_d = S_FIN;
				if (sts.present) begin
					cmd.merge_wr = 1'b1;
				end else if (sts.full) begin
					cmd.set_full = 1'b1;
				end else begin
					cmd.mark_wr = 1'b1;
					state_d     = S_UP;
				end
			end
			S_UP: begin
				if (sts.at_root) begin
					cmd.place = 1'b1;
					state_d   = S_FIN;
				end else begin
					cmd.up_rd = 1'b1;
					state_d   = S_UPCMP;
				end
			end
			S_UPCMP: begin
				if (sts.up_stop) begin
					cmd.place = 1'b1;
					state_d   = S_FIN;
				end else begin
					cmd.up_move = 1'b1;
					state_d     = S_UP;
				end
			end
			S_TOPD: begin
				cmd.top_cap = 1'b1;
				if (sts.func == FN_EXTRACT) begin
					cmd.last_rd = 1'b1;
					state_d     = S_LAST;
				end else begin
					state_d = S_FIN;
				end
			end
			S_LAST: begin
				cmd.last_cap = 1'b1;
				state_d      = S_SUM;
			end
			S_SUM: begin
				cmd.sum_cap = 1'b1;
				state_d     = S_DN;
			end
			S_DN: begin
				if (sts.has_l) begin
					cmd.rd_l = 1'b1;
					state_d  = S_DNL;
				end else begin
					cmd.place = 1'b1;
					state_d   = S_FIN;
				end
			end
			S_DNL: begin
				cmd.cap_l = 1'b1;
				if (sts.has_r) begin
					cmd.rd_r = 1'b1;
					state_d  = S_DNR;
				end else begin
					state_d = S_DNC;
				end
			end
			S_DNR: begin
				cmd.cap_r = 1'b1;
				state_d   = S_DNC;
			end
			S_DNC: begin
				if (sts.pick_none) begin
					cmd.place = 1'b1;
					state_d   = S_FIN;
				end else begin
					cmd.dn_move = 1'b1;
					state_d     = S_DN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/merging_max_heap_by_degree_core.sv]
// top level of the merging max-heap of polynomial terms keyed by degree
//
//  channel  direction  handshake             word
//  input    in         in_valid / in_ready   func, degree, coef, source_id
//  output   out        out_valid / out_ready status, out_degree, out_coef,
//                                            out_source_id, merged, entry_total
//
// one word at a time: a new word is accepted only after the previous result has
// been loaded into the output register; insert sifts up and extract sifts down the
// heap level by level; after reset the degree accumulator memory is cleared entry
// by entry with in_ready low; a stalled output holds the next result in its final state
module merging_max_heap_by_degree_core #(
	parameter int HEAP_CAPACITY = mhd_pkg::HEAP_CAPACITY_DEF,
	parameter int DEGREE_COUNT  = mhd_pkg::DEGREE_COUNT_DEF,
	parameter int COEF_BITS     = mhd_pkg::COEF_BITS_DEF,
	parameter int ID_BITS       = mhd_pkg::ID_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mhd_pkg::FUNC_W-1:0]        func,
	input  logic [mhd_pkg::DEG_W-1:0]         degree,
	input  logic signed [mhd_pkg::COEF_W-1:0] coef,
	input  logic [mhd_pkg::SRC_W-1:0]         source_id,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mhd_pkg::STATUS_W-1:0]      status,
	output logic [mhd_pkg::DEG_W-1:0]         out_degree,
	output logic signed [mhd_pkg::COEF_W-1:0] out_coef,
	output logic [mhd_pkg::SRC_W-1:0]         out_source_id,
	output logic                              merged,
	output logic [mhd_pkg::TOTAL_W-1:0]       entry_total
);
	import mhd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mhd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mhd_dpath #(
		.HEAP_CAPACITY (HEAP_CAPACITY),
		.DEGREE_COUNT  (DEGREE_COUNT),
		.COEF_BITS     (COEF_BITS),
		.ID_BITS       (ID_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.degree        (degree),
		.coef          (coef),
		.source_id     (source_id),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.out_degree    (out_degree),
		.out_coef      (out_coef),
		.out_source_id (out_source_id),
		.merged        (merged),
		.entry_total   (entry_total)
	);

endmodule

[test/testbench.sv]
// testbench for the merging max-heap of polynomial terms keyed by degree
module testbench;
	import mhd_pkg::*;

	localparam int CAP = HEAP_CAPACITY_DEF;
	localparam int NDEG = DEGREE_COUNT_DEF;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [DEG_W-1:0] deg;
		logic [COEF_W-1:0] coef;
		logic [SRC_W-1:0] id;
	} term_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DEG_W-1:0] deg;
		logic [COEF_W-1:0] coef;
		logic [SRC_W-1:0] id;
		logic merged;
		logic [TOTAL_W-1:0] total;
	} heap_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FUNC_W-1:0] func = '0;
	logic [DEG_W-1:0] degree = '0;
	logic signed [COEF_W-1:0] coef = '0;
	logic [SRC_W-1:0] source_id = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [DEG_W-1:0] out_degree;
	logic signed [COEF_W-1:0] out_coef;
	logic [SRC_W-1:0] out_source_id;
	logic merged;
	logic [TOTAL_W-1:0] entry_total;

	merging_max_heap_by_degree_core DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	term_t heap_q[CAP];
	int unsigned heap_n;
	bit deg_live[NDEG];
	logic [COEF_W-1:0] deg_acc[NDEG];
	heap_result_t expected_q[$];

	int errors = 0;
	int words_sent = 0;
	int results_seen = 0;
	int merges_seen = 0;
	int fulls_seen = 0;
	longint cycles = 0;
	bit hold_off = 1'b0;
	bit stall_mode = 1'b1;
	bit burst_mode = 1'b1;
	int burst_left = 0;

	task automatic swap_terms(int unsigned a, int unsigned b);
		term_t t;
		t = heap_q[a];
		heap_q[a] = heap_q[b];
		heap_q[b] = t;
	endtask

	task automatic predict_heap(logic [FUNC_W-1:0] f, logic [DEG_W-1:0] d,
			logic [COEF_W-1:0] c, logic [SRC_W-1:0] s);
		heap_result_t r;
		term_t top;
		int unsigned i, p, l, big;
		r = '0;
		if (f == FN_INSERT) begin
			if (deg_live[d]) begin
				deg_acc[d] = deg_acc[d] + c;
				r.merged = 1'b1;
			end else if (heap_n >= CAP) begin
				r.status = ST_FULL;
			end else begin
				i = heap_n;
				heap_q[i] = '{deg: d, coef: c, id: s};
				heap_n++;
				while (i > 0) begin
					p = (i - 1) / 2;
					if (heap_q[p].deg >= heap_q[i].deg) break;
					swap_terms(i, p);
					i = p;
				end
				deg_live[d] = 1'b1;
			end
		end else if (f == FN_EXTRACT || f == FN_PEEK) begin
			if (heap_n == 0) begin
				r.status = ST_EMPTY;
			end else begin
				top = heap_q[0];
				if (f == FN_EXTRACT) begin
					heap_n--;
					heap_q[0] = heap_q[heap_n];
					i = 0;
					forever begin
						l = 2 * i + 1;
						big = i;
						if (l < heap_n && heap_q[l].deg > heap_q[big].deg) big = l;
						if (l + 1 < heap_n && heap_q[l+1].deg > heap_q[big].deg) big = l + 1;
						if (big == i) break;
						swap_terms(i, big);
						i = big;
					end
					top.coef = top.coef + deg_acc[top.deg];
					deg_acc[top.deg] = '0;
					deg_live[top.deg] = 1'b0;
				end
				r.deg = top.deg;
				r.coef = top.coef;
				r.id = top.id;
			end
		end
		r.total = heap_n[TOTAL_W-1:0];
		expected_q.insert(expected_q.size(), r);
	endtask

	task automatic send_word(logic [FUNC_W-1:0] f, logic [DEG_W-1:0] d,
			logic [COEF_W-1:0] c, logic [SRC_W-1:0] s);
		int gap;
		if (burst_mode) begin
			if (burst_left == 0) begin
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 20);
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		func <= f;
		degree <= d;
		coef <= c;
		source_id <= s;
		predict_heap(f, d, c, s);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [DEG_W-1:0] pick_degree();
		// mostly a narrow band so that merges happen often
		if ($urandom_range(0, 3) == 0) return DEG_W'($urandom);
		return DEG_W'($urandom_range(0, 63));
	endfunction

	task automatic test_directed();
		send_word(FN_EXTRACT, '0, '0, '0);
		send_word(FN_PEEK, '0, '0, '0);
		send_word(FN_UNUSED, 10'h3ff, 32'hffffffff, 16'hffff);
		send_word(FN_INSERT, 10'd0, 32'h80000000, 16'h0000);
		send_word(FN_INSERT, 10'h3ff, 32'h7fffffff, 16'hffff);
		send_word(FN_INSERT, 10'h3ff, 32'h00000001, 16'h1234);
		send_word(FN_INSERT, 10'd0, 32'hffffffff, 16'h5555);
		send_word(FN_INSERT, 10'h155, 32'h55555555, 16'haaaa);
		send_word(FN_INSERT, 10'h2aa, 32'haaaaaaaa, 16'h5555);
		send_word(FN_PEEK, '0, '0, '0);
		send_word(FN_EXTRACT, '0, '0, '0);
		send_word(FN_UNUSED, '0, '0, '0);
		send_word(FN_EXTRACT, '0, '0, '0);
		send_word(FN_EXTRACT, '0, '0, '0);
		send_word(FN_EXTRACT, '0, '0, '0);
		send_word(FN_EXTRACT, '0, '0, '0);
		send_word(FN_PEEK, '0, '0, '0);
		drain_results();
	endtask

	task automatic test_random_mix(int count);
		int k, w;
		for (k = 0; k < count; k++) begin
			w = $urandom_range(0, 99);
			if (w < 55)
				send_word(FN_INSERT, pick_degree(), $urandom, SRC_W'($urandom));
			else if (w < 80)
				send_word(FN_EXTRACT, DEG_W'($urandom), $urandom, SRC_W'($urandom));
			else if (w < 95)
				send_word(FN_PEEK, DEG_W'($urandom), $urandom, SRC_W'($urandom));
			else
				send_word(FN_UNUSED, DEG_W'($urandom), $urandom, SRC_W'($urandom));
		end
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		burst_mode = 1'b0;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			test_random_mix(30);
		join
		burst_mode = 1'b1;
		drain_results();
	endtask

	task automatic test_fill_to_capacity();
		int k;
		stall_mode = 1'b0;
		burst_mode = 1'b0;
		while (heap_n != 0) send_word(FN_EXTRACT, '0, '0, '0);
		for (k = 0; k < CAP; k++)
			send_word(FN_INSERT, DEG_W'(k), $urandom, SRC_W'($urandom));
		send_word(FN_INSERT, 10'd17, 32'h7fffffff, 16'hffff);
		send_word(FN_INSERT, 10'd1023, 32'h00000001, 16'h0001);
		send_word(FN_PEEK, '0, '0, '0);
		for (k = 0; k < 20; k++)
			send_word(FN_EXTRACT, '0, '0, '0);
		stall_mode = 1'b1;
		burst_mode = 1'b1;
		drain_results();
	endtask

	// output side: stall pattern, comparison and counters
	always @(posedge clk) begin
		heap_result_t exp_r;
		cycles <= cycles + 1;
		if (out_valid && out_ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word status=%0d deg=%0d", $time,
					status, out_degree);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (exp_r.merged) merges_seen++;
				if (exp_r.status == ST_FULL) fulls_seen++;
				if (status !== exp_r.status) begin
					$display("%0t: status exp %0d got %0d", $time, exp_r.status, status);
					errors++;
				end
				if (out_degree !== exp_r.deg) begin
					$display("%0t: degree exp %0d got %0d", $time, exp_r.deg, out_degree);
					errors++;
				end
				if (out_coef !== exp_r.coef) begin
					$display("%0t: coef exp %h got %h", $time, exp_r.coef, out_coef);
					errors++;
				end
				if (out_source_id !== exp_r.id) begin
					$display("%0t: source id exp %h got %h", $time, exp_r.id,
						out_source_id);
					errors++;
				end
				if (merged !== exp_r.merged) begin
					$display("%0t: merged exp %0d got %0d", $time, exp_r.merged, merged);
					errors++;
				end
				if (entry_total !== exp_r.total) begin
					$display("%0t: total exp %0d got %0d", $time, exp_r.total,
						entry_total);
					errors++;
				end
			end
		end
		if (hold_off)
			out_ready <= 1'b0;
		else if (!stall_mode)
			out_ready <= 1'b1;
		else if ((cycles % 300) < 120)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		heap_n = 0;
		foreach (deg_live[k]) begin
			deg_live[k] = 1'b0;
			deg_acc[k] = '0;
		end
		@(posedge clk);
		test_directed();
		test_random_mix(25);
		drain_results();
		test_backpressure();
		test_random_mix(25);
		drain_results();
		test_fill_to_capacity();
		test_random_mix(10);
		drain_results();
		$display("sent %0d words, checked %0d results (%0d merges, %0d full drops)",
			words_sent, results_seen, merges_seen, fulls_seen);
		if (errors == 0 && expected_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

[merging_max_heap_by_degree_core.f]
src/mhd_pkg.sv
src/mhd_dpath.sv
src/mhd_ctrl.sv
src/merging_max_heap_by_degree_core.sv
test/testbench.sv
